// File: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue unit.
package spq_pkg;

   // Number of cells in the chain (2 to 256).
   localparam int CAPACITY = 16;
   // Payload width of value and priority.
   localparam int DATA_W   = 32;
   // Width of the entry count reported on the result channel.
   localparam int COUNT_OUT_W = 5;
   // Internal occupancy counter, wide enough for CAPACITY and for the report.
   localparam int OCC_W = ($clog2(CAPACITY + 1) > COUNT_OUT_W) ?
                          $clog2(CAPACITY + 1) : COUNT_OUT_W;

   // Command codes on the request channel.
   typedef enum logic {
      CMD_ENQ = 1'b0,
      CMD_DEQ = 1'b1
   } cmd_code_type;

   // One held entry.
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } entry_type;

   // Operation broadcast to every cell in a cycle.
   typedef struct packed {
      logic enq;   // insert the broadcast entry (queue not full)
      logic deq;   // pop the head (queue not empty)
   } cell_op_type;

   // What a cell shows to its neighbors.
   typedef struct packed {
      entry_type entry;
      logic      occupied;
      logic      greater;   // broadcast entry would be placed at or before this cell
   } cell_link_type;

endpackage

// File: rtl/spq_if.sv
// Request and response channel interfaces of the sorted priority queue unit.
interface spq_req_if;
   import spq_pkg::*;

   logic                     valid;
   logic                     ready;
   cmd_code_type             cmd;
   logic signed [DATA_W-1:0] item_value;
   logic signed [DATA_W-1:0] item_priority;

   modport source (output valid, cmd, item_value, item_priority, input ready);
   modport sink   (input valid, cmd, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          out_valid;
   logic signed [DATA_W-1:0]      out_value;
   logic signed [DATA_W-1:0]      out_priority;
   logic        [COUNT_OUT_W-1:0] entry_count;
   logic                          overflow;

   modport source (output valid, out_valid, out_value, out_priority, entry_count,
                   overflow, input ready);
   modport sink   (input valid, out_valid, out_value, out_priority, entry_count,
                   overflow, output ready);
endinterface

// File: rtl/spq_cell.sv
// One queue slot: holds an entry and shifts with its neighbors on insert and pop.
module spq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  spq_pkg::cell_op_type   op,
   input  spq_pkg::entry_type     ins_entry,
   input  spq_pkg::cell_link_type left_link,
   input  spq_pkg::cell_link_type right_link,
   output spq_pkg::cell_link_type link
);
   import spq_pkg::*;

   entry_type entry_ff, entry_in;
   logic      occ_ff, occ_in;
   logic      greater;

   // Strictly greater priority goes ahead; empty cells always accept.
   assign greater = !occ_ff || ($signed(ins_entry.prio) > $signed(entry_ff.prio));

   // Next slot contents
   always_comb begin
      entry_in = entry_ff;
      occ_in   = occ_ff;
      if (op.enq) begin
         if (left_link.greater) begin
            // insert point is upstream: make room by shifting down
            entry_in = left_link.entry;
            occ_in   = left_link.occupied;
         end else if (greater) begin
            entry_in = ins_entry;
            occ_in   = 1'b1;
         end
      end else if (op.deq) begin
         entry_in = right_link.entry;
         occ_in   = right_link.occupied;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      entry_ff <= entry_in;
   end

   assign link.entry    = entry_ff;
   assign link.occupied = occ_ff;
   assign link.greater  = greater;

endmodule

// File: rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue unit: cell chain, count and response register.
//
// Bounded priority queue of CAPACITY entries, highest priority at the head.
// Request word: cmd (enqueue or dequeue head), item_value, item_priority.
// Each request word gives exactly one response word: out_valid/out_value/
// out_priority for a dequeued entry (zeros otherwise), the entry count after
// the request, and overflow when an enqueue found the queue full and was dropped.
// Equal priorities leave in arrival order.
// Every slot is a cell of a chain; all cells compare the incoming priority at
// once and shift toward their neighbor in the same cycle, so a request is
// finished in the cycle it is accepted. The response word is registered and shows
// in the cycle after; throughput is one request per cycle while the receiver keeps up.
// The response register sits between the two sides: a new request is taken
// whenever the register is empty or its word is being taken in the same cycle;
// while the receiver stalls with a word pending, req ready stays low.
// Reset (synchronous, active high) empties the queue and the response register;
// no clearing pass is needed.
module sorted_priority_queue_unit (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_word,
   spq_rsp_if.source rsp_word
);
   import spq_pkg::*;

   cell_link_type link [CAPACITY];
   cell_op_type   op;
   entry_type     ins_entry;
   logic          accept;
   logic          full;
   logic          empty;
   logic          do_deq;
   logic          do_ovf;

   logic [OCC_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff;
   logic                     out_valid_ff;
   logic signed [DATA_W-1:0] out_value_ff;
   logic signed [DATA_W-1:0] out_prio_ff;
   logic                     overflow_ff;

   // Handshake
   assign req_word.ready = !rsp_valid_ff || rsp_word.ready;
   assign accept         = req_word.valid && req_word.ready;

   // Command decode against the chain ends
   assign full  = link[CAPACITY-1].occupied;
   assign empty = !link[0].occupied;
   assign op.enq = accept && (req_word.cmd == CMD_ENQ) && !full;
   assign op.deq = accept && (req_word.cmd == CMD_DEQ) && !empty;
   assign do_deq = op.deq;
   assign do_ovf = accept && (req_word.cmd == CMD_ENQ) && full;

   assign ins_entry.value = req_word.item_value;
   assign ins_entry.prio  = req_word.item_priority;

   // Cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_type left_l, right_l;
      if (i == 0) begin : g_head
         assign left_l = '0;
      end else begin : g_mid_l
         assign left_l = link[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_l = '0;
      end else begin : g_mid_r
         assign right_l = link[i+1];
      end
      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .ins_entry  (ins_entry),
         .left_link  (left_l),
         .right_link (right_l),
         .link       (link[i])
      );
   end

   // Entry count
   always_comb begin
      count_in = count_ff;
      if (op.enq) begin
         count_in = count_ff + OCC_W'(1);
      end else if (op.deq) begin
         count_in = count_ff - OCC_W'(1);
      end
   end

   // Count and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_word.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         out_valid_ff <= do_deq;
         out_value_ff <= do_deq ? link[0].entry.value : '0;
         out_prio_ff  <= do_deq ? link[0].entry.prio  : '0;
         overflow_ff  <= do_ovf;
      end
   end

   assign rsp_word.valid        = rsp_valid_ff;
   assign rsp_word.out_valid    = out_valid_ff;
   assign rsp_word.out_value    = out_value_ff;
   assign rsp_word.out_priority = out_prio_ff;
   assign rsp_word.entry_count  = count_ff[COUNT_OUT_W-1:0];
   assign rsp_word.overflow     = overflow_ff;

   // Checks
   a_empty_count : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == empty)
      else $error("head cell occupancy disagrees with entry count");

   a_full_count : assert property (@(posedge clock) disable iff (reset)
      (count_ff == OCC_W'(CAPACITY)) == full)
      else $error("tail cell occupancy disagrees with entry count");

   a_rsp_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(out_valid_ff && overflow_ff))
      else $error("response word flags both dequeue and overflow");

   a_ovf_hold : assert property (@(posedge clock) disable iff (reset)
      do_ovf |=> $stable(count_ff))
      else $error("dropped enqueue changed the entry count");

endmodule

// File: test/sorted_priority_queue_unit_test.sv
// Self-checking testbench for the sorted priority queue unit.
module sorted_priority_queue_unit_test;
   import spq_pkg::*;

   // One response word as the block reports it.
   typedef struct packed {
      logic                   out_valid;
      logic [DATA_W-1:0]      out_value;
      logic [DATA_W-1:0]      out_priority;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic                   overflow;
   } result_type;

   // Directed row: typed-in result is used only when fixed is set.
   typedef struct packed {
      logic         fixed;
      cmd_code_type cmd;
      logic [31:0]  value;
      logic [31:0]  prio;
      result_type   typed;
   } directed_row_type;

   localparam int DIRECTED_N   = 23;
   localparam int RANDOM_ITEMS = 1730;
   localparam int HOLD_CYCLES  = 80;

   localparam directed_row_type DIRECTED_ROWS [0:DIRECTED_N-1] = '{
      // dequeue from empty queue after reset
      '{1'b1, CMD_DEQ, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '{1'b0, 32'h0, 32'h0, 5'd0, 1'b0}},
      // fill to capacity: extremes, ties at zero, max and min
      '{1'b1, CMD_ENQ, 32'h7FFF_FFFF, 32'h0000_0000, '{1'b0, 32'h0, 32'h0, 5'd1, 1'b0}},
      '{1'b1, CMD_ENQ, 32'h8000_0000, 32'h7FFF_FFFF, '{1'b0, 32'h0, 32'h0, 5'd2, 1'b0}},
      '{1'b1, CMD_ENQ, 32'h0000_0000, 32'h8000_0000, '{1'b0, 32'h0, 32'h0, 5'd3, 1'b0}},
      '{1'b1, CMD_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '{1'b0, 32'h0, 32'h0, 5'd4, 1'b0}},
      '{1'b1, CMD_ENQ, 32'hAAAA_AAAA, 32'h0000_0001, '{1'b0, 32'h0, 32'h0, 5'd5, 1'b0}},
      '{1'b1, CMD_ENQ, 32'h5555_5555, 32'h0000_0000, '{1'b0, 32'h0, 32'h0, 5'd6, 1'b0}},
      '{1'b1, CMD_ENQ, 32'h0000_0001, 32'h0000_0000, '{1'b0, 32'h0, 32'h0, 5'd7, 1'b0}},
      '{1'b1, CMD_ENQ, 32'h0000_0002, 32'h7FFF_FFFF, '{1'b0, 32'h0, 32'h0, 5'd8, 1'b0}},
      '{1'b1, CMD_ENQ, 32'h0000_0003, 32'h8000_0000, '{1'b0, 32'h0, 32'h0, 5'd9, 1'b0}},
      '{1'b1, CMD_ENQ, 32'h0000_0004, 32'h0000_0005, '{1'b0, 32'h0, 32'h0, 5'd10, 1'b0}},
      '{1'b1, CMD_ENQ, 32'h0000_0005, 32'hFFFF_FFFB, '{1'b0, 32'h0, 32'h0, 5'd11, 1'b0}},
      '{1'b1, CMD_ENQ, 32'h0000_0006, 32'h0000_0064, '{1'b0, 32'h0, 32'h0, 5'd12, 1'b0}},
      '{1'b1, CMD_ENQ, 32'h0000_0007, 32'h0000_0000, '{1'b0, 32'h0, 32'h0, 5'd13, 1'b0}},
      '{1'b1, CMD_ENQ, 32'h0000_0008, 32'h0000_0002, '{1'b0, 32'h0, 32'h0, 5'd14, 1'b0}},
      '{1'b1, CMD_ENQ, 32'h0000_0009, 32'h0000_0003, '{1'b0, 32'h0, 32'h0, 5'd15, 1'b0}},
      '{1'b1, CMD_ENQ, 32'h0000_000A, 32'h0000_0004, '{1'b0, 32'h0, 32'h0, 5'd16, 1'b0}},
      // enqueue into full queue is dropped
      '{1'b1, CMD_ENQ, 32'h1234_5678, 32'h7FFF_FFFF, '{1'b0, 32'h0, 32'h0, 5'd16, 1'b1}},
      // pops: max-priority ties leave in arrival order
      '{1'b0, CMD_DEQ, 32'h0000_0000, 32'h0000_0000, '0},
      '{1'b0, CMD_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0},
      '{1'b0, CMD_DEQ, 32'h8000_0000, 32'h8000_0000, '0},
      '{1'b0, CMD_DEQ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0},
      '{1'b0, CMD_DEQ, 32'h0000_0000, 32'h0000_0000, '0}
   };

   logic clock;
   logic reset;

   spq_req_if req_bus();
   spq_rsp_if rsp_bus();

   sorted_priority_queue_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_bus),
      .rsp_word (rsp_bus)
   );

   // Predicted queue contents, head at index 0.
   entry_type  held_entries[$];
   // Results still owed by the block, oldest first.
   result_type pending_results[$];
   int         mismatch_count;
   bit         hold_off_request;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Generous limit on the whole run.
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   // Apply one request word to the predicted queue.
   function automatic result_type predict_result(cmd_code_type cmd,
                                                 logic [DATA_W-1:0] value,
                                                 logic [DATA_W-1:0] prio);
      result_type res;
      entry_type  fresh;
      int         slot;
      res = '0;
      if (cmd == CMD_ENQ) begin
         if (held_entries.size() >= CAPACITY) begin
            res.overflow = 1'b1;
         end else begin
            fresh.value = value;
            fresh.prio  = prio;
            slot = held_entries.size();
            // new entry goes after every entry of greater or equal priority
            for (int i = 0; i < held_entries.size(); i++) begin
               if ($signed(prio) > $signed(held_entries[i].prio)) begin
                  slot = i;
                  break;
               end
            end
            held_entries.insert(slot, fresh);
         end
      end else if (held_entries.size() > 0) begin
         res.out_valid    = 1'b1;
         res.out_value    = held_entries[0].value;
         res.out_priority = held_entries[0].prio;
         void'(held_entries.pop_front());
      end
      res.entry_count = COUNT_OUT_W'(held_entries.size());
      return res;
   endfunction

   // Drive one word at the falling edge and wait for it to be taken.
   task automatic offer_word(input cmd_code_type cmd, input logic [31:0] value,
                             input logic [31:0] prio, output result_type predicted);
      @(negedge clock);
      req_bus.valid         <= 1'b1;
      req_bus.cmd           <= cmd;
      req_bus.item_value    <= value;
      req_bus.item_priority <= prio;
      do @(posedge clock); while (!req_bus.ready);
      predicted = predict_result(cmd, value, prio);
   endtask

   // Idle the request side, with noise on the payload.
   task automatic sender_gap(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_bus.valid         <= 1'b0;
         req_bus.cmd           <= ($urandom_range(0, 1) == 0) ? CMD_ENQ : CMD_DEQ;
         req_bus.item_value    <= $urandom;
         req_bus.item_priority <= $urandom;
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Response checker.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("response word with no expectation pending");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("out_valid", 32'(want.out_valid), 32'(rsp_bus.out_valid));
            compare_field("out_value", want.out_value, rsp_bus.out_value);
            compare_field("out_priority", want.out_priority, rsp_bus.out_priority);
            compare_field("entry_count", 32'(want.entry_count), 32'(rsp_bus.entry_count));
            compare_field("overflow", 32'(want.overflow), 32'(rsp_bus.overflow));
         end
      end
   end

   // Receiver: stall pattern is redrawn among always, random and sparse ready; long hold-off on request.
   initial begin : receiver
      int hold_left;
      int tick;
      int mode;
      hold_left = 0;
      tick      = 0;
      mode      = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_off_request && hold_left == 0) begin
            hold_left        = HOLD_CYCLES;
            hold_off_request = 1'b0;
         end
         if (tick % 64 == 0) mode = $urandom_range(0, 2);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= ($urandom_range(0, 1) == 1);
               default: rsp_bus.ready <= (tick % 4 == 0);
            endcase
         end
      end
   end

   // Stimulus.
   initial begin
      result_type   predicted;
      cmd_code_type cmd;
      logic [31:0]  value;
      logic [31:0]  prio;
      int           sent;
      int           burst;
      int           enq_pct;

      mismatch_count        = 0;
      hold_off_request      = 1'b0;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.cmd           = CMD_ENQ;
      req_bus.item_value    = '0;
      req_bus.item_priority = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIRECTED_N; r++) begin
         offer_word(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].value,
                    DIRECTED_ROWS[r].prio, predicted);
         pending_results.push_back(DIRECTED_ROWS[r].fixed ? DIRECTED_ROWS[r].typed
                                                          : predicted);
      end

      // random bursts, each leaning toward filling, draining or neither
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         case ($urandom_range(0, 2))
            0:       enq_pct = 85;
            1:       enq_pct = 15;
            default: enq_pct = 50;
         endcase
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            case ($urandom_range(0, 9))
               0:       value = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
               default: value = $urandom;
            endcase
            // narrow priorities make ties common
            case ($urandom_range(0, 9))
               0, 1, 2, 3: prio = 32'($signed($urandom_range(0, 6)) - 3);
               4:          prio = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
               default:    prio = $urandom;
            endcase
            offer_word(cmd, value, prio, predicted);
            pending_results.push_back(predicted);
            sent++;
            if (sent == 400 || sent == 1100) hold_off_request = 1'b1;
            if (sent == 800) begin
               // pause until the block has answered everything
               sender_gap(1);
               while (pending_results.size() != 0) @(posedge clock);
            end
         end
         if ($urandom_range(0, 1) == 1) sender_gap($urandom_range(1, 6));
      end
      sender_gap(1);

      // drain
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sorted_priority_queue_unit.f
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
test/sorted_priority_queue_unit_test.sv
